[rtl/ple_pkg.sv]
// shared types, constants and codes for the positional list engine
`default_nettype none

package ple_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int ACT_W    = 3;
    localparam int POS_W    = 9;
    localparam int CNT_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;

    localparam int IN_W     = ACT_W + POS_W + VAL_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = VAL_W + POS_W + CNT_W + STAT_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_SEARCH = 3'd4,
        ACT_COUNT  = 3'd5
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  position;
        logic [ACT_W-1:0]  action;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  entry_count;
        logic [POS_W-1:0]  found_position;
        logic [VAL_W-1:0]  read_value;
    } res_t;

endpackage

`default_nettype wire

[rtl/ple_ram.sv]
// generic single-port-write, single-port-read synchronous ram
`default_nettype none

module ple_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/ple_ctrl.sv]
// request sequencer: decodes a request and walks the entry memory
`default_nettype none

module ple_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ple_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output ple_pkg::res_t      res
);

    ple_pkg::state_t state_reg, state_next;
    ple_pkg::req_t   req_reg, req_next;

    logic [ple_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ple_pkg::CNT_W-1:0]  ptr_reg, ptr_next;
    logic [ple_pkg::CNT_W-1:0]  left_reg, left_next;
    logic                       pend_reg, pend_next;
    logic [ple_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ple_pkg::VAL_W-1:0]  rd_value_reg, rd_value_next;
    logic [ple_pkg::POS_W-1:0]  found_reg, found_next;
    logic [ple_pkg::STAT_W-1:0] status_reg, status_next;

    logic                       wr_en;
    logic [ple_pkg::ADDR_W-1:0] wr_addr;
    logic [ple_pkg::VAL_W-1:0]  wr_data;
    logic                       rd_en;
    logic [ple_pkg::ADDR_W-1:0] rd_addr;
    logic [ple_pkg::VAL_W-1:0]  rd_data;

    logic pos_lt_cnt;
    logic pos_gt_cnt;
    logic is_full;
    logic hit;
    logic walk_end;

    ple_ram #(
        .DEPTH(ple_pkg::CAPACITY),
        .WIDTH(ple_pkg::VAL_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign pos_lt_cnt = req_reg.position < count_reg;
    assign pos_gt_cnt = req_reg.position > count_reg;
    assign is_full    = count_reg >= ple_pkg::CNT_W'(ple_pkg::CAPACITY);
    assign hit        = pend_reg && (req_reg.action == ple_pkg::ACT_SEARCH)
                        && (rd_data == req_reg.value);
    assign walk_end   = (left_reg == '0) && !pend_reg;

    assign req_ready = (state_reg == ple_pkg::ST_IDLE);
    assign res_valid = (state_reg == ple_pkg::ST_DONE);

    assign res.read_value     = rd_value_reg;
    assign res.found_position = found_reg;
    assign res.entry_count    = count_reg;
    assign res.status         = status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ple_pkg::ST_DECODE;
                end
            end
            ple_pkg::ST_DECODE:
            begin
                unique case (req_reg.action)
                    ple_pkg::ACT_READ,
                    ple_pkg::ACT_REMOVE:
                        state_next = pos_lt_cnt ? ple_pkg::ST_WALK : ple_pkg::ST_DONE;
                    ple_pkg::ACT_INSERT:
                        state_next = (!pos_gt_cnt && !is_full) ? ple_pkg::ST_WALK
                                                                : ple_pkg::ST_DONE;
                    ple_pkg::ACT_SEARCH:
                        state_next = ple_pkg::ST_WALK;
                    default:
                        state_next = ple_pkg::ST_DONE;
                endcase
            end
            ple_pkg::ST_WALK:
            begin
                if (hit || walk_end)
                begin
                    state_next = ple_pkg::ST_DONE;
                end
            end
            ple_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ple_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        req_next       = req_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rd_value_next  = rd_value_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = req_reg.position[ple_pkg::ADDR_W-1:0];
        wr_data        = req_reg.value;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[ple_pkg::ADDR_W-1:0];

        unique case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    rd_value_next = '0;
                    found_next    = '1;
                    status_next   = ple_pkg::STAT_OK;
                    pend_next     = 1'b0;
                    left_next     = '0;
                end
            end
            ple_pkg::ST_DECODE:
            begin
                unique case (req_reg.action)
                    ple_pkg::ACT_READ:
                    begin
                        if (pos_lt_cnt)
                        begin
                            ptr_next  = req_reg.position;
                            left_next = ple_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ple_pkg::STAT_RANGE;
                        end
                    end
                    ple_pkg::ACT_WRITE:
                    begin
                        if (pos_lt_cnt)
                        begin
                            wr_en = 1'b1;
                        end
                        else
                        begin
                            status_next = ple_pkg::STAT_RANGE;
                        end
                    end
                    ple_pkg::ACT_INSERT:
                    begin
                        priority if (pos_gt_cnt)
                        begin
                            status_next = ple_pkg::STAT_RANGE;
                        end
                        else if (is_full)
                        begin
                            status_next = ple_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // walk down from the last entry, moving each back one place
                            ptr_next  = count_reg - 1'b1;
                            left_next = count_reg - req_reg.position;
                        end
                    end
                    ple_pkg::ACT_REMOVE:
                    begin
                        if (pos_lt_cnt)
                        begin
                            // walk up from the entry after the hole
                            ptr_next  = req_reg.position + 1'b1;
                            left_next = count_reg - req_reg.position - 1'b1;
                        end
                        else
                        begin
                            status_next = ple_pkg::STAT_RANGE;
                        end
                    end
                    ple_pkg::ACT_SEARCH:
                    begin
                        ptr_next  = '0;
                        left_next = count_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ple_pkg::ST_WALK:
            begin
                // issue side: one read per cycle
                if (left_reg != '0)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_reg[ple_pkg::ADDR_W-1:0];
                    ptr_next       = (req_reg.action == ple_pkg::ACT_INSERT)
                                     ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                    left_next      = left_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[ple_pkg::ADDR_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // return side: data of the read issued last cycle
                // writes land two entries away from the current read, so no overlap
                if (pend_reg)
                begin
                    unique case (req_reg.action)
                        ple_pkg::ACT_READ:
                            rd_value_next = rd_data;
                        ple_pkg::ACT_INSERT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pend_addr_reg + 1'b1;
                            wr_data = rd_data;
                        end
                        ple_pkg::ACT_REMOVE:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pend_addr_reg - 1'b1;
                            wr_data = rd_data;
                        end
                        ple_pkg::ACT_SEARCH:
                        begin
                            if (hit)
                            begin
                                found_next = ple_pkg::POS_W'(pend_addr_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // walk drained: finish the structural change
                if (walk_end)
                begin
                    unique case (req_reg.action)
                        ple_pkg::ACT_INSERT:
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        ple_pkg::ACT_REMOVE:
                            count_next = count_reg - 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ple_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        rd_value_reg  <= rd_value_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
    end

endmodule

`default_nettype wire

[rtl/positional_list_engine_core.sv]
// top level of the positional list engine: stream ports and output register
`default_nettype none

// Ordered list of up to 256 signed 32-bit values held in one synchronous
// entry ram. Each input transaction is one request (read, write, insert,
// remove, search, count) and yields exactly one result transaction with the
// read value, the found position (all ones when absent or not a search), the
// entry count after the request and a status (ok, out of range, full).
// Requests are served one at a time. A request passes the decode state, the
// walk state if it walks the ram, then the done state and the output
// register. The walk reads 1 entry for read, count - position for insert,
// count - position - 1 for remove, up to count for search (it stops at the
// first match). An insert or remove that moves no entry and a search of an
// empty list still pass the walk state; write, count and refused requests
// skip it. The walk is bound by the single read port of the entry ram,
// which moves one entry per cycle. The next request is taken in the cycle
// after the previous result is registered, even while that result still
// sits in the output register. There is no clearing pass after reset:
// only positions below the count are ever read, and each of those was
// written first.

module positional_list_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action [2:0], position [11:3], value [43:12], zero fill [47:44]
    input  wire logic [ple_pkg::IN_BYTES*8-1:0]  s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value [31:0], found_position [40:32], entry_count [49:41],
    // status [51:50], zero fill [55:52]
    output logic      [ple_pkg::OUT_BYTES*8-1:0] m_tdata
);

    ple_pkg::req_t req;
    ple_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic [ple_pkg::OUT_BYTES*8-1:0]    m_tdata_reg, m_tdata_next;

    // unpack the request fields, lowest field first
    assign req = ple_pkg::req_t'(s_tdata[ple_pkg::IN_W-1:0]);

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output register frees as soon as the downstream takes its transaction
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_tdata_next = (ple_pkg::OUT_BYTES*8)'(res);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
